[rtl/gsi_pkg.sv]
// Shared types and constants for the three-point gyro angle integrator.
package gsi_pkg;

	// Fixed widths of the sample and result fields.
	localparam int RATE_FIELD_WIDTH = 16;
	localparam int TIME_WIDTH       = 32;
	localparam int OUT_WIDTH        = 48;

	localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
	localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_NEG,
		ST_BIAS,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} state_t;

	// Step strobes and serial gap bits sent from the sequencer to each axis unit.
	typedef struct packed {
		logic load;
		logic mul;
		logic neg;
		logic bias;
		logic div;
		logic fin;
		logic g0_bit;
		logic g1_bit;
	} axis_ctrl_t;

endpackage

[rtl/gsi_in_if.sv]
// Sample channel: three gyro samples per axis and their timestamps.
interface gsi_in_if;
	logic valid;
	logic ready;
	logic [gsi_pkg::RATE_FIELD_WIDTH-1:0] rate_x_first;
	logic [gsi_pkg::RATE_FIELD_WIDTH-1:0] rate_x_middle;
	logic [gsi_pkg::RATE_FIELD_WIDTH-1:0] rate_x_last;
	logic [gsi_pkg::RATE_FIELD_WIDTH-1:0] rate_y_first;
	logic [gsi_pkg::RATE_FIELD_WIDTH-1:0] rate_y_middle;
	logic [gsi_pkg::RATE_FIELD_WIDTH-1:0] rate_y_last;
	logic [gsi_pkg::RATE_FIELD_WIDTH-1:0] rate_z_first;
	logic [gsi_pkg::RATE_FIELD_WIDTH-1:0] rate_z_middle;
	logic [gsi_pkg::RATE_FIELD_WIDTH-1:0] rate_z_last;
	logic [gsi_pkg::TIME_WIDTH-1:0] time_first;
	logic [gsi_pkg::TIME_WIDTH-1:0] time_middle;
	logic [gsi_pkg::TIME_WIDTH-1:0] time_last;

	modport source (
		output valid, rate_x_first, rate_x_middle, rate_x_last,
		rate_y_first, rate_y_middle, rate_y_last,
		rate_z_first, rate_z_middle, rate_z_last,
		time_first, time_middle, time_last,
		input ready
	);

	modport sink (
		input valid, rate_x_first, rate_x_middle, rate_x_last,
		rate_y_first, rate_y_middle, rate_y_last,
		rate_z_first, rate_z_middle, rate_z_last,
		time_first, time_middle, time_last,
		output ready
	);
endinterface

[rtl/gsi_out_if.sv]
// Result channel: per-axis angle increments and running totals.
interface gsi_out_if;
	logic valid;
	logic ready;
	logic signed [gsi_pkg::OUT_WIDTH-1:0] delta_x;
	logic signed [gsi_pkg::OUT_WIDTH-1:0] delta_y;
	logic signed [gsi_pkg::OUT_WIDTH-1:0] delta_z;
	logic signed [gsi_pkg::OUT_WIDTH-1:0] total_x;
	logic signed [gsi_pkg::OUT_WIDTH-1:0] total_y;
	logic signed [gsi_pkg::OUT_WIDTH-1:0] total_z;

	modport source (
		output valid, delta_x, delta_y, delta_z, total_x, total_y, total_z,
		input ready
	);

	modport sink (
		input valid, delta_x, delta_y, delta_z, total_x, total_y, total_z,
		output ready
	);
endinterface

[rtl/gsi_axis.sv]
// One axis: serial gap multiply, sign split, bit-serial scaling divide, saturation.
module gsi_axis #(
	parameter int MICROS_PER_SECOND = 1000000,
	parameter int FRAC_BITS         = 16,
	parameter int RATE_WIDTH        = 16
) (
	input  logic                                        clk,
	input  gsi_pkg::axis_ctrl_t                         ctrl,
	input  logic [gsi_pkg::RATE_FIELD_WIDTH-1:0]        rate_first,
	input  logic [gsi_pkg::RATE_FIELD_WIDTH-1:0]        rate_middle,
	input  logic [gsi_pkg::RATE_FIELD_WIDTH-1:0]        rate_last,
	output logic signed [gsi_pkg::OUT_WIDTH-1:0]        delta
);

	// Weighted rate sums, product sum, and scaled dividend widths.
	localparam int SW = RATE_WIDTH + 2;
	localparam int NW = SW + gsi_pkg::TIME_WIDTH + 1;
	localparam int XW = NW + FRAC_BITS + 1;
	localparam int OW = gsi_pkg::OUT_WIDTH;
	localparam logic [63:0] DEN  = 64'(3) * 64'(MICROS_PER_SECOND);
	localparam logic [63:0] HALF = DEN / 64'(2);
	localparam int DW = $clog2(DEN + 64'(1));

	logic [RATE_WIDTH+gsi_pkg::RATE_FIELD_WIDTH-1:0] ext_first, ext_middle, ext_last;
	logic signed [RATE_WIDTH-1:0] p0, p1, p2;
	logic signed [SW-1:0] a_q, b_q;
	logic signed [NW-1:0] acc_q;
	logic [NW-1:0]        mag;
	logic                 neg_q;
	logic [XW-1:0]        x_q;
	logic [DW-1:0]        r_q;
	logic [DW:0]          trial;
	logic                 fits;
	logic [OW-1:0]        q_q;
	logic                 ovf_q;
	logic                 sat;
	logic signed [OW-1:0] delta_q;

	// Each rate is its low RATE_WIDTH bits, two's complement; wider fields zero-fill.
	assign ext_first  = {{RATE_WIDTH{1'b0}}, rate_first};
	assign ext_middle = {{RATE_WIDTH{1'b0}}, rate_middle};
	assign ext_last   = {{RATE_WIDTH{1'b0}}, rate_last};
	assign p0 = ext_first[RATE_WIDTH-1:0];
	assign p1 = ext_middle[RATE_WIDTH-1:0];
	assign p2 = ext_last[RATE_WIDTH-1:0];

	// Magnitude of the exact product sum.
	assign mag = acc_q[NW-1] ? NW'(-acc_q) : NW'(acc_q);

	// Restoring division step: bring down one dividend bit and try the subtract.
	assign trial = {r_q, x_q[XW-1]};
	assign fits  = (trial >= DEN[DW:0]);

	// The quotient saturates once any bit at or above the sign position appears.
	assign sat = ovf_q | q_q[OW-1];

	// Equal gaps reduce to the same form: g*(p0+2p1) + g*(2p1+p2) = g*(p0+4p1+p2),
	// so both cases share one serial multiply over the two gaps.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a_q   <= SW'(p0) + (SW'(p1) <<< 1);
			b_q   <= (SW'(p1) <<< 1) + SW'(p2);
			acc_q <= '0;
		end else if (ctrl.mul) begin
			acc_q <= (acc_q <<< 1)
				+ (ctrl.g0_bit ? NW'(a_q) : NW'(0))
				+ (ctrl.g1_bit ? NW'(b_q) : NW'(0));
		end
	end

	// Dividend preparation and the bit-serial divide by three times the tick rate.
	always_ff @(posedge clk) begin
		if (ctrl.neg) begin
			neg_q <= acc_q[NW-1];
			x_q   <= XW'(mag) << FRAC_BITS;
			r_q   <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (ctrl.bias) begin
			x_q <= x_q + XW'(HALF);
		end else if (ctrl.div) begin
			x_q   <= x_q << 1;
			r_q   <= fits ? DW'(trial - DEN[DW:0]) : DW'(trial);
			q_q   <= {q_q[OW-2:0], fits};
			ovf_q <= ovf_q | q_q[OW-1];
		end
	end

	// Apply the sign and saturate to the output range.
	always_ff @(posedge clk) begin
		if (ctrl.fin) begin
			if (neg_q) begin
				delta_q <= sat ? gsi_pkg::OUT_MIN : -$signed(q_q);
			end else begin
				delta_q <= sat ? gsi_pkg::OUT_MAX : $signed(q_q);
			end
		end
	end

	assign delta = delta_q;

endmodule

[rtl/gyro_simpson_integrator.sv]
// Three-point gyro angle integrator with saturating running totals per axis.
// A transaction is loaded, then passes through the serial gap multiply, the sign split, the
// rounding bias, the one-bit-per-cycle scaling divide in each axis unit, and the final sign and
// saturation step; it then waits to commit until the previous result has been taken.
// A new transaction is accepted only after the previous one has committed.
// Reset clears the sequencer, the result valid flag and the three angle totals to zero.
module gyro_simpson_integrator #(
	parameter int MICROS_PER_SECOND = 1000000,
	parameter int FRAC_BITS         = 16,
	parameter int RATE_WIDTH        = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	gsi_in_if.sink     samples,
	gsi_out_if.source  results
);

	localparam int TW        = gsi_pkg::TIME_WIDTH;
	localparam int OW        = gsi_pkg::OUT_WIDTH;
	localparam int DIV_STEPS = RATE_WIDTH + 2 + TW + 1 + FRAC_BITS + 1;
	localparam int STEPS_MAX = (DIV_STEPS > TW) ? DIV_STEPS : TW;
	localparam int CW        = $clog2(STEPS_MAX);

	gsi_pkg::state_t     state_q, state_d;
	gsi_pkg::axis_ctrl_t ctrl;
	logic                commit;
	logic [CW-1:0]       cnt_q;
	logic [TW-1:0]       gap0_q, gap1_q;
	logic                out_valid_q;
	logic signed [OW-1:0] dx, dy, dz;
	logic signed [OW-1:0] delta_x_q, delta_y_q, delta_z_q;
	logic signed [OW-1:0] total_x_q, total_y_q, total_z_q;
	logic signed [OW:0]   sum_x, sum_y, sum_z;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gsi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and step strobes for the axis units.
	always_comb begin
		state_d     = state_q;
		ctrl        = '0;
		ctrl.g0_bit = gap0_q[TW-1];
		ctrl.g1_bit = gap1_q[TW-1];
		commit      = 1'b0;
		unique case (state_q)
			gsi_pkg::ST_IDLE: begin
				if (samples.valid) begin
					ctrl.load = 1'b1;
					state_d   = gsi_pkg::ST_MUL;
				end
			end
			gsi_pkg::ST_MUL: begin
				ctrl.mul = 1'b1;
				if (cnt_q == '0) begin
					state_d = gsi_pkg::ST_NEG;
				end
			end
			gsi_pkg::ST_NEG: begin
				ctrl.neg = 1'b1;
				state_d  = gsi_pkg::ST_BIAS;
			end
			gsi_pkg::ST_BIAS: begin
				ctrl.bias = 1'b1;
				state_d   = gsi_pkg::ST_DIV;
			end
			gsi_pkg::ST_DIV: begin
				ctrl.div = 1'b1;
				if (cnt_q == '0) begin
					state_d = gsi_pkg::ST_FIN;
				end
			end
			gsi_pkg::ST_FIN: begin
				ctrl.fin = 1'b1;
				state_d  = gsi_pkg::ST_DONE;
			end
			gsi_pkg::ST_DONE: begin
				if (!out_valid_q || results.ready) begin
					commit  = 1'b1;
					state_d = gsi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gsi_pkg::ST_IDLE;
			end
		endcase
	end

	assign samples.ready = (state_q == gsi_pkg::ST_IDLE);

	// Step counter and the gap shift registers, consumed MSB first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.load) begin
			cnt_q <= CW'(TW - 1);
		end else if (ctrl.bias) begin
			cnt_q <= CW'(DIV_STEPS - 1);
		end else if (ctrl.mul || ctrl.div) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			gap0_q <= samples.time_middle - samples.time_first;
			gap1_q <= samples.time_last - samples.time_middle;
		end else if (ctrl.mul) begin
			gap0_q <= gap0_q << 1;
			gap1_q <= gap1_q << 1;
		end
	end

	// Per-axis arithmetic units.
	gsi_axis #(
		.MICROS_PER_SECOND (MICROS_PER_SECOND),
		.FRAC_BITS         (FRAC_BITS),
		.RATE_WIDTH        (RATE_WIDTH)
	) u_axis_x (
		.clk         (clk),
		.ctrl        (ctrl),
		.rate_first  (samples.rate_x_first),
		.rate_middle (samples.rate_x_middle),
		.rate_last   (samples.rate_x_last),
		.delta       (dx)
	);

	gsi_axis #(
		.MICROS_PER_SECOND (MICROS_PER_SECOND),
		.FRAC_BITS         (FRAC_BITS),
		.RATE_WIDTH        (RATE_WIDTH)
	) u_axis_y (
		.clk         (clk),
		.ctrl        (ctrl),
		.rate_first  (samples.rate_y_first),
		.rate_middle (samples.rate_y_middle),
		.rate_last   (samples.rate_y_last),
		.delta       (dy)
	);

	gsi_axis #(
		.MICROS_PER_SECOND (MICROS_PER_SECOND),
		.FRAC_BITS         (FRAC_BITS),
		.RATE_WIDTH        (RATE_WIDTH)
	) u_axis_z (
		.clk         (clk),
		.ctrl        (ctrl),
		.rate_first  (samples.rate_z_first),
		.rate_middle (samples.rate_z_middle),
		.rate_last   (samples.rate_z_last),
		.delta       (dz)
	);

	// Running totals: one guard bit catches overflow, which clamps to the sign of the sum.
	assign sum_x = (OW + 1)'(total_x_q) + (OW + 1)'(dx);
	assign sum_y = (OW + 1)'(total_y_q) + (OW + 1)'(dy);
	assign sum_z = (OW + 1)'(total_z_q) + (OW + 1)'(dz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_x_q <= '0;
			total_y_q <= '0;
			total_z_q <= '0;
		end else if (commit) begin
			total_x_q <= (sum_x[OW] != sum_x[OW-1])
				? (sum_x[OW] ? gsi_pkg::OUT_MIN : gsi_pkg::OUT_MAX) : sum_x[OW-1:0];
			total_y_q <= (sum_y[OW] != sum_y[OW-1])
				? (sum_y[OW] ? gsi_pkg::OUT_MIN : gsi_pkg::OUT_MAX) : sum_y[OW-1:0];
			total_z_q <= (sum_z[OW] != sum_z[OW-1])
				? (sum_z[OW] ? gsi_pkg::OUT_MIN : gsi_pkg::OUT_MAX) : sum_z[OW-1:0];
		end
	end

	// Result register and its valid flag.
	always_ff @(posedge clk) begin
		if (commit) begin
			delta_x_q <= dx;
			delta_y_q <= dy;
			delta_z_q <= dz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign results.valid   = out_valid_q;
	assign results.delta_x = delta_x_q;
	assign results.delta_y = delta_y_q;
	assign results.delta_z = delta_z_q;
	assign results.total_x = total_x_q;
	assign results.total_y = total_y_q;
	assign results.total_z = total_z_q;

endmodule

[test/gyro_simpson_integrator_tb.sv]
// Self-checking testbench for the three-point gyro angle integrator.
module gyro_simpson_integrator_tb;

	localparam int MICROS_PER_SECOND = 1000000;
	localparam int FRAC_BITS         = 16;
	localparam int RATE_WIDTH        = 16;
	localparam int RANDOM_PER_PHASE  = 306;
	localparam int HOLD_CYCLES       = 1500;
	localparam int DRAIN_LIMIT       = 20000;
	localparam int SETTLE_CYCLES     = 160;

	typedef logic [gsi_pkg::RATE_FIELD_WIDTH-1:0] rate_t;
	typedef logic [gsi_pkg::TIME_WIDTH-1:0] stamp_t;
	typedef logic signed [gsi_pkg::OUT_WIDTH-1:0] angle_t;

	// One sample window, laid out in the order of the channel fields.
	typedef struct packed {
		rate_t  rate_x_first;
		rate_t  rate_x_middle;
		rate_t  rate_x_last;
		rate_t  rate_y_first;
		rate_t  rate_y_middle;
		rate_t  rate_y_last;
		rate_t  rate_z_first;
		rate_t  rate_z_middle;
		rate_t  rate_z_last;
		stamp_t time_first;
		stamp_t time_middle;
		stamp_t time_last;
	} gyro_window_t;

	// Increments and running totals for one window.
	typedef struct packed {
		angle_t delta_x;
		angle_t delta_y;
		angle_t delta_z;
		angle_t total_x;
		angle_t total_y;
		angle_t total_z;
	} angle_result_t;

	// Predicts the angles of each accepted window and checks them against the block.
	class angle_scoreboard;
		angle_result_t expected_angles[$];
		angle_t run_x;
		angle_t run_y;
		angle_t run_z;
		int errors;

		function new();
			run_x = '0;
			run_y = '0;
			run_z = '0;
			errors = 0;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10) begin
				$display("mismatch: %s", msg);
			end
		endfunction

		// Turn an exact sum of microseconds times counts into a rounded fixed-point angle.
		// Rounding is to nearest with ties away from zero, done on the magnitude.
		function angle_t scale_to_angle(longint sum);
			logic [63:0] den;
			logic [63:0] mag;
			logic [63:0] whole;
			logic [63:0] rem;
			logic [63:0] frac;
			logic [63:0] whole_limit;
			logic [63:0] val;
			angle_t scaled;
			bit neg;
			den = 64'(3 * MICROS_PER_SECOND);
			neg = sum < 0;
			mag = neg ? 64'd0 - 64'(sum) : 64'(sum);
			whole = mag / den;
			rem = mag % den;
			frac = ((rem << FRAC_BITS) + den / 2) / den;
			whole_limit = (64'd1 << (gsi_pkg::OUT_WIDTH - 1)) >> FRAC_BITS;
			if (whole > whole_limit) begin
				return neg ? gsi_pkg::OUT_MIN : gsi_pkg::OUT_MAX;
			end
			val = (whole << FRAC_BITS) + frac;
			if (neg) begin
				if (val >= (64'd1 << (gsi_pkg::OUT_WIDTH - 1))) begin
					return gsi_pkg::OUT_MIN;
				end
				scaled = val[gsi_pkg::OUT_WIDTH-1:0];
				return -scaled;
			end
			if (val > 64'(gsi_pkg::OUT_MAX)) begin
				return gsi_pkg::OUT_MAX;
			end
			return val[gsi_pkg::OUT_WIDTH-1:0];
		endfunction

		// Simpson's rule when both gaps match, two trapezoid-like halves otherwise.
		function angle_t axis_delta(rate_t a, rate_t b, rate_t c, stamp_t g0, stamp_t g1);
			longint p0;
			longint p1;
			longint p2;
			longint lg0;
			longint lg1;
			longint sum;
			p0 = $signed(a[RATE_WIDTH-1:0]);
			p1 = $signed(b[RATE_WIDTH-1:0]);
			p2 = $signed(c[RATE_WIDTH-1:0]);
			lg0 = {32'd0, g0};
			lg1 = {32'd0, g1};
			if (g0 == g1) begin
				sum = lg0 * (p0 + 4 * p1 + p2);
			end else begin
				sum = lg0 * (p0 + 2 * p1) + lg1 * (2 * p1 + p2);
			end
			return scale_to_angle(sum);
		endfunction

		function angle_t add_saturated(angle_t total, angle_t delta);
			longint sum;
			sum = total;
			sum += delta;
			if (sum > gsi_pkg::OUT_MAX) begin
				return gsi_pkg::OUT_MAX;
			end
			if (sum < gsi_pkg::OUT_MIN) begin
				return gsi_pkg::OUT_MIN;
			end
			return sum[gsi_pkg::OUT_WIDTH-1:0];
		endfunction

		function void note_window(gyro_window_t w);
			stamp_t g0;
			stamp_t g1;
			angle_result_t r;
			g0 = w.time_middle - w.time_first;
			g1 = w.time_last - w.time_middle;
			r.delta_x = axis_delta(w.rate_x_first, w.rate_x_middle, w.rate_x_last, g0, g1);
			r.delta_y = axis_delta(w.rate_y_first, w.rate_y_middle, w.rate_y_last, g0, g1);
			r.delta_z = axis_delta(w.rate_z_first, w.rate_z_middle, w.rate_z_last, g0, g1);
			run_x = add_saturated(run_x, r.delta_x);
			run_y = add_saturated(run_y, r.delta_y);
			run_z = add_saturated(run_z, r.delta_z);
			r.total_x = run_x;
			r.total_y = run_y;
			r.total_z = run_z;
			expected_angles.push_back(r);
		endfunction

		function void compare(string name, angle_t want, angle_t got);
			if (got !== want) begin
				flag($sformatf("%s expected %0d, got %0d", name, want, got));
			end
		endfunction

		function void check_result(angle_result_t got);
			angle_result_t want;
			if (expected_angles.size() == 0) begin
				flag("result transaction with no window pending");
				return;
			end
			want = expected_angles.pop_front();
			compare("delta_x", want.delta_x, got.delta_x);
			compare("delta_y", want.delta_y, got.delta_y);
			compare("delta_z", want.delta_z, got.delta_z);
			compare("total_x", want.total_x, got.total_x);
			compare("total_y", want.total_y, got.total_y);
			compare("total_z", want.total_z, got.total_z);
		endfunction

		function int pending();
			return expected_angles.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	gsi_in_if  in_ch();
	gsi_out_if out_ch();

	gyro_simpson_integrator #(
		.MICROS_PER_SECOND(MICROS_PER_SECOND),
		.FRAC_BITS(FRAC_BITS),
		.RATE_WIDTH(RATE_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(in_ch),
		.results(out_ch)
	);

	angle_scoreboard sb = new();

	// Idle and stall rates of the current phase, in percent.
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	// Each increment asks the receiver for one long hold-off.
	int hold_requests = 0;

	// Clock generation.
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Watchdog against a hung handshake.
	initial begin
		#16000000;
		$display("end of test: mismatches");
		$finish;
	end

	// Record every accepted window.
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			sb.note_window({in_ch.rate_x_first, in_ch.rate_x_middle, in_ch.rate_x_last,
				in_ch.rate_y_first, in_ch.rate_y_middle, in_ch.rate_y_last,
				in_ch.rate_z_first, in_ch.rate_z_middle, in_ch.rate_z_last,
				in_ch.time_first, in_ch.time_middle, in_ch.time_last});
		end
	end

	// Check every accepted result.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			sb.check_result({out_ch.delta_x, out_ch.delta_y, out_ch.delta_z,
				out_ch.total_x, out_ch.total_y, out_ch.total_z});
		end
	end

	// Result receiver: random stalls, plus a long hold-off on request.
	initial begin
		int hold_left;
		int holds_served;
		hold_left = 0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && holds_served != hold_requests) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= !(receiver_stall_pct > 0 &&
					$urandom_range(99) < receiver_stall_pct);
			end
		end
	end

	function automatic bit sender_idles();
		return sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct;
	endfunction

	// Offer one window and return in the cycle it is accepted.
	task automatic drive_window(gyro_window_t w);
		while (sender_idles()) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		{in_ch.rate_x_first, in_ch.rate_x_middle, in_ch.rate_x_last,
			in_ch.rate_y_first, in_ch.rate_y_middle, in_ch.rate_y_last,
			in_ch.rate_z_first, in_ch.rate_z_middle, in_ch.rate_z_last,
			in_ch.time_first, in_ch.time_middle, in_ch.time_last} <= w;
		@(posedge clk);
		while (!in_ch.ready) begin
			@(posedge clk);
		end
	endtask

	function automatic gyro_window_t window_of(rate_t x0, rate_t x1, rate_t x2,
		rate_t y0, rate_t y1, rate_t y2, rate_t z0, rate_t z1, rate_t z2,
		stamp_t t0, stamp_t t1, stamp_t t2);
		return {x0, x1, x2, y0, y1, y2, z0, z1, z2, t0, t1, t2};
	endfunction

	// Each axis holds one constant rate over the window.
	function automatic gyro_window_t steady_window(rate_t rx, rate_t ry, rate_t rz,
		stamp_t t0, stamp_t t1, stamp_t t2);
		return window_of(rx, rx, rx, ry, ry, ry, rz, rz, rz, t0, t1, t2);
	endfunction

	function automatic rate_t random_rate();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return rate_t'($urandom_range(200) - 100);
			default: return rate_t'($urandom);
		endcase
	endfunction

	// Mostly realistic sample spacing, with zero, wrapped, reversed and huge gaps mixed in.
	function automatic gyro_window_t random_window();
		gyro_window_t w;
		stamp_t gap;
		int pick;
		w.rate_x_first  = random_rate();
		w.rate_x_middle = random_rate();
		w.rate_x_last   = random_rate();
		w.rate_y_first  = random_rate();
		w.rate_y_middle = random_rate();
		w.rate_y_last   = random_rate();
		w.rate_z_first  = random_rate();
		w.rate_z_middle = random_rate();
		w.rate_z_last   = random_rate();
		w.time_first    = $urandom;
		pick = $urandom_range(99);
		if (pick < 40) begin
			gap = $urandom_range(20000, 500);
			w.time_middle = w.time_first + gap;
			w.time_last   = w.time_middle + gap;
		end else if (pick < 70) begin
			w.time_middle = w.time_first + $urandom_range(20000);
			w.time_last   = w.time_middle + $urandom_range(20000);
		end else if (pick < 80) begin
			w.time_middle = w.time_first + ($urandom_range(1) ? 0 : $urandom_range(5000));
			w.time_last   = w.time_middle + ($urandom_range(1) ? 0 : $urandom_range(5000));
		end else if (pick < 90) begin
			w.time_middle = $urandom;
			w.time_last   = $urandom;
		end else begin
			gap = $urandom;
			w.time_middle = w.time_first + gap;
			w.time_last   = w.time_middle + gap;
		end
		return w;
	endfunction

	// Extremes, saturation of the totals in both directions, and odd timestamps.
	task automatic run_directed();
		drive_window(steady_window(16'h0000, 16'h0000, 16'h0000, 32'd0, 32'd0, 32'd0));
		drive_window(steady_window(16'h0001, 16'hffff, 16'h7fff, 32'd100, 32'd101, 32'd102));
		// Largest equal gaps: x and z run into the top, y into the bottom, and stay there.
		repeat (9) begin
			drive_window(steady_window(16'h7fff, 16'h8000, 16'h7fff,
				32'h0000_0000, 32'hffff_ffff, 32'hffff_fffe));
		end
		// Opposite signs pull the saturated totals back.
		drive_window(steady_window(16'h8000, 16'h7fff, 16'h0000,
			32'h0000_0000, 32'hffff_ffff, 32'hffff_fffe));
		drive_window(steady_window(16'h8000, 16'h7fff, 16'h8000,
			32'h0000_0000, 32'hffff_ffff, 32'hffff_fffd));
		// Timestamps wrapping through zero with equal gaps.
		drive_window(window_of(16'h8000, 16'h7fff, 16'h1234, 16'h0001, 16'h8000, 16'hffff,
			16'h7fff, 16'h7fff, 16'h8000, 32'hffff_fff0, 32'h0000_0010, 32'h0000_0030));
		// Timestamps out of order.
		drive_window(window_of(16'h0100, 16'hff00, 16'h0200, 16'h8000, 16'h8000, 16'h8000,
			16'h0010, 16'h0020, 16'h0030, 32'd1000, 32'd500, 32'd2000));
		// One gap zero, then the other.
		drive_window(window_of(16'h7fff, 16'h0001, 16'h8000, 16'h0003, 16'h0004, 16'h0005,
			16'hfff0, 16'h0010, 16'hffff, 32'd5000, 32'd5000, 32'd9000));
		drive_window(window_of(16'h7fff, 16'h0001, 16'h8000, 16'h0003, 16'h0004, 16'h0005,
			16'hfff0, 16'h0010, 16'hffff, 32'd5000, 32'd9000, 32'd9000));
		// Rates that cancel, and tiny negative sums that round toward zero.
		drive_window(window_of(16'hffff, 16'h0000, 16'h0001, 16'hffff, 16'hffff, 16'hffff,
			16'h0001, 16'h0000, 16'h0000, 32'd7, 32'd8, 32'd9));
		// Alternating bit patterns in every field.
		drive_window(window_of(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
			16'h5555, 16'haaaa, 16'h5555, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555));
		// Largest unequal gaps.
		drive_window(steady_window(16'h8000, 16'h8000, 16'h7fff,
			32'h0000_0000, 32'hffff_ffff, 32'hffff_fffd));
	endtask

	task automatic run_random(int count, int idle_pct, int stall_pct);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		repeat (count) begin
			drive_window(random_window());
		end
	endtask

	// Main sequence.
	initial begin
		int waited;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		{in_ch.rate_x_first, in_ch.rate_x_middle, in_ch.rate_x_last,
			in_ch.rate_y_first, in_ch.rate_y_middle, in_ch.rate_y_last,
			in_ch.rate_z_first, in_ch.rate_z_middle, in_ch.rate_z_last,
			in_ch.time_first, in_ch.time_middle, in_ch.time_last} = '0;
		out_ch.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_random(RANDOM_PER_PHASE, 0, 0);
		run_random(RANDOM_PER_PHASE, 88, 0);
		run_random(RANDOM_PER_PHASE, 0, 88);
		run_random(RANDOM_PER_PHASE, 23, 23);
		// Long receiver hold-off while windows keep coming, so the input backs up.
		hold_requests++;
		run_random(RANDOM_PER_PHASE, 0, 0);
		in_ch.valid <= 1'b0;

		// Drain everything still in flight.
		receiver_stall_pct = 0;
		waited = 0;
		while (sb.pending() > 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (sb.pending() > 0) begin
			sb.flag($sformatf("%0d expected results never arrived", sb.pending()));
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sb.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
